// ----- src/m64bh_pkg.sv -----
`timescale 1ns / 1ps

package m64bh_pkg;

  // Hash word, key length and chunk byte count widths
  localparam int HASH_W  = 64;
  localparam int LEN_W   = 32;
  localparam int BYTES_W = 4;

  // Packed request word: chunk_data, chunk_bytes, key_length, padded to bytes
  localparam int REQ_BITS = HASH_W + BYTES_W + LEN_W;
  localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;

  // Mixing constants
  localparam logic [HASH_W-1:0] MIX_MUL    = 64'hc6a4a7935bd1e995;
  localparam int                MIX_SHIFT  = 47;
  localparam logic [HASH_W-1:0] SEED_RESET = 64'h00000000c70f6907;

  // Fold the high bits back into the low bits
  function automatic logic [HASH_W-1:0] xor_shift(input logic [HASH_W-1:0] v);
    xor_shift = v ^ (v >> MIX_SHIFT);
  endfunction

endpackage

// ----- src/m64bh_mul.sv -----
`timescale 1ns / 1ps

// Multiply a 64-bit operand by the mixing constant, modulo 2^64, on one
// 32x32 multiplier: three partial products, accumulated in the cycle after each.
module m64bh_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [m64bh_pkg::HASH_W-1:0] a_in,
  output logic                        done,
  output logic [m64bh_pkg::HASH_W-1:0] p
);
  import m64bh_pkg::*;

  localparam int HALF_W = HASH_W / 2;

  logic [HASH_W-1:0] a;
  logic [HASH_W-1:0] acc;
  logic [HASH_W-1:0] prod;
  logic [HASH_W-1:0] prod_next;
  logic [HALF_W-1:0] op_a;
  logic [HALF_W-1:0] op_b;
  logic [1:0]        cnt;
  logic              busy;

  // Select the halves for this step: lo*lo, hi*lo, lo*hi
  always_comb begin
    case (cnt)
      2'd0: begin
        op_a = a[HALF_W-1:0];
        op_b = MIX_MUL[HALF_W-1:0];
      end
      2'd1: begin
        op_a = a[HASH_W-1:HALF_W];
        op_b = MIX_MUL[HALF_W-1:0];
      end
      default: begin
        op_a = a[HALF_W-1:0];
        op_b = MIX_MUL[HASH_W-1:HALF_W];
      end
    endcase
    prod_next = {{HALF_W{1'b0}}, op_a} * {{HALF_W{1'b0}}, op_b};
  end

  // Sequence the partial products and accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 2'd0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 2'd0;
      done <= 1'b0;
    end else if (busy) begin
      cnt <= cnt + 2'd1;
      if (cnt == 2'd3) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Operand, product and accumulator registers
  always_ff @(posedge clk) begin
    if (start) begin
      a <= a_in;
    end else if (busy) begin
      prod <= prod_next;
      case (cnt)
        2'd0: acc <= acc;
        2'd1: acc <= prod;
        default: acc <= acc + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
      endcase
    end
  end

  assign p = acc;

endmodule

// ----- src/murmur64_byte_hash.sv -----
`timescale 1ns / 1ps

// 64-bit Murmur-style byte hash. A key arrives as little-endian chunks of up to
// eight bytes; the first chunk carries the total key length, which enters the
// initial hash together with the seed register. Full chunks are premixed,
// short chunks are masked and folded in directly, and the last chunk returns
// the finalized hash. All multiplies share one iterative unit built on a single
// 32x32 multiplier. A full chunk takes three multiplies, two to premix and one
// to fold, a short chunk one and an empty chunk none; a first chunk adds the
// length multiply and a last chunk the final one, and no chunk is accepted
// until the previous one is through. The finished hash waits in an output
// register, so a new key can start while the previous result is still
// pending. The seed may be written only while no key is in progress.
module murmur64_byte_hash (
  input  logic                         clk,
  input  logic                         rst,
  // Seed register write
  input  logic                         cfg_wen,
  input  logic [m64bh_pkg::HASH_W-1:0] cfg_wdata,
  // Chunk requests
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // chunk_data [63:0], chunk_bytes [67:64], key_length [99:68], zero pad
  input  logic [m64bh_pkg::REQ_W-1:0]  s_axis_tdata,
  // first_chunk
  input  logic                         s_axis_tuser,
  // last_chunk
  input  logic                         s_axis_tlast,
  // Hash results
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // hash_value [63:0]
  output logic [m64bh_pkg::HASH_W-1:0] m_axis_tdata
);
  import m64bh_pkg::*;

  localparam int NBYTE = HASH_W / 8;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LEN  = 9'b000000010,
    S_DATA = 9'b000000100,
    S_PRE1 = 9'b000001000,
    S_PRE2 = 9'b000010000,
    S_FOLD = 9'b000100000,
    S_TAIL = 9'b001000000,
    S_FIN  = 9'b010000000,
    S_EMIT = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [HASH_W-1:0]  seed;
  logic [HASH_W-1:0]  running_hash;
  logic [HASH_W-1:0]  data;
  logic [BYTES_W-1:0] nbytes;
  logic               last;

  logic [HASH_W-1:0]  in_data;
  logic [BYTES_W-1:0] in_bytes;
  logic [LEN_W-1:0]   in_len;
  logic               s_accept;
  logic               full;
  logic               nonzero;
  logic [HASH_W-1:0]  masked;
  logic               emit_ok;

  logic               mul_start;
  logic [HASH_W-1:0]  mul_a;
  logic               mul_done;
  logic [HASH_W-1:0]  mul_p;

  // Unpack the request word
  assign in_data  = s_axis_tdata[HASH_W-1:0];
  assign in_bytes = s_axis_tdata[HASH_W+BYTES_W-1:HASH_W];
  assign in_len   = s_axis_tdata[HASH_W+BYTES_W+LEN_W-1:HASH_W+BYTES_W];

  // Take no request while reset is held
  assign s_axis_tready = (state == S_IDLE) && !rst;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Classify the chunk; counts of eight and above are full chunks
  assign full    = nbytes[BYTES_W-1];
  assign nonzero = (nbytes != '0);

  // Keep only the valid bytes of a short chunk
  always_comb begin
    for (int i = 0; i < NBYTE; i++) begin
      masked[i*8 +: 8] = (BYTES_W'(i) < nbytes) ? data[i*8 +: 8] : 8'd0;
    end
  end

  assign emit_ok = !m_axis_tvalid || m_axis_tready;

  m64bh_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a_in  (mul_a),
    .done  (mul_done),
    .p     (mul_p)
  );

  // Sequence the multiplies of one chunk
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = '0;
    case (state)
      S_IDLE: begin
        if (s_accept) begin
          if (s_axis_tuser) begin
            mul_start  = 1'b1;
            mul_a      = {{(HASH_W-LEN_W){1'b0}}, in_len};
            state_next = S_LEN;
          end else begin
            state_next = S_DATA;
          end
        end
      end
      S_LEN: begin
        if (mul_done) state_next = S_DATA;
      end
      S_DATA: begin
        if (full) begin
          mul_start  = 1'b1;
          mul_a      = data;
          state_next = S_PRE1;
        end else if (nonzero) begin
          mul_start  = 1'b1;
          mul_a      = running_hash ^ masked;
          state_next = S_FOLD;
        end else begin
          state_next = S_TAIL;
        end
      end
      S_PRE1: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = xor_shift(mul_p);
          state_next = S_PRE2;
        end
      end
      S_PRE2: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = running_hash ^ mul_p;
          state_next = S_FOLD;
        end
      end
      S_FOLD: begin
        if (mul_done) state_next = S_TAIL;
      end
      S_TAIL: begin
        if (last) begin
          mul_start  = 1'b1;
          mul_a      = xor_shift(running_hash);
          state_next = S_FIN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FIN: begin
        if (mul_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (emit_ok) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State, seed, running hash and output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      seed          <= SEED_RESET;
      running_hash  <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) seed <= cfg_wdata;
      // Load the initial hash, then each fold result
      if (state == S_LEN && mul_done) running_hash <= seed ^ mul_p;
      if (state == S_FOLD && mul_done) running_hash <= mul_p;
      // Hand over the finalized hash, or drop a taken one
      if (state == S_EMIT && emit_ok) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Capture the request payload and the result word
  always_ff @(posedge clk) begin
    if (s_accept) begin
      data   <= in_data;
      nbytes <= in_bytes;
      last   <= s_axis_tlast;
    end
    if (state == S_EMIT && emit_ok) m_axis_tdata <= xor_shift(mul_p);
  end

endmodule

// ----- sim/murmur64_byte_hash_test.sv -----
`timescale 1ns / 1ps

module murmur64_byte_hash_test;

  import m64bh_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_e;

  // Predict the finalized hash of each key and hold the hashes still owed
  class hash_checker;
    logic [HASH_W-1:0] seed;
    logic [HASH_W-1:0] folded;
    logic [HASH_W-1:0] pending_hashes[$];
    int mismatches;
    int hashes_checked;

    function new();
      seed = SEED_RESET;
      folded = '0;
      mismatches = 0;
      hashes_checked = 0;
    endfunction

    function logic [HASH_W-1:0] fold_high(input logic [HASH_W-1:0] v);
      return v ^ (v >> MIX_SHIFT);
    endfunction

    // Advance the running hash by one accepted chunk request
    function void note_chunk(input logic [HASH_W-1:0] data, input logic [BYTES_W-1:0] nbytes,
                             input bit first, input bit last, input logic [LEN_W-1:0] len);
      logic [HASH_W-1:0] h;
      logic [HASH_W-1:0] mask;
      h = folded;
      if (first) h = seed ^ ({{(HASH_W-LEN_W){1'b0}}, len} * MIX_MUL);
      if (nbytes >= 8) begin
        h = h ^ (fold_high(data * MIX_MUL) * MIX_MUL);
        h = h * MIX_MUL;
      end else if (nbytes != 0) begin
        mask = {HASH_W{1'b1}} >> (HASH_W - 8 * nbytes);
        h = h ^ (data & mask);
        h = h * MIX_MUL;
      end
      folded = h;
      if (last) pending_hashes.push_back(fold_high(fold_high(h) * MIX_MUL));
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Compare a delivered hash with the oldest one owed
    task check_hash(input logic [HASH_W-1:0] got);
      logic [HASH_W-1:0] want;
      if (pending_hashes.size() == 0) begin
        report($sformatf("hash %h delivered with none owed", got));
      end else begin
        want = pending_hashes.pop_front();
        hashes_checked++;
        if (got !== want) report($sformatf("hash_value %h, predicted %h", got, want));
      end
    endtask

    function int owed();
      return pending_hashes.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wen = 1'b0;
  logic [HASH_W-1:0]   cfg_wdata = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [REQ_W-1:0]    s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [HASH_W-1:0]   m_axis_tdata;

  hash_checker hashes = new();

  int  cycle_count = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  chunks_sent = 0;
  int  keys_sent = 0;
  int  seeds_written = 0;
  int  hold_off_len = 0;
  bit  hold_off_tag = 1'b0;

  murmur64_byte_hash u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Take hashes, stall at random, hold off on request from the stimulus
  bit hold_seen_tag = 1'b0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) hashes.check_hash(m_axis_tdata);
    if (hold_off_tag != hold_seen_tag) begin
      hold_seen_tag = hold_off_tag;
      hold_left = hold_off_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [HASH_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Offer one chunk request and hold it until accepted
  task automatic send_chunk(input logic [HASH_W-1:0] data, input logic [BYTES_W-1:0] nbytes,
                            input bit first, input bit last, input logic [LEN_W-1:0] len);
    logic [REQ_W-1:0] req;
    req = '0;
    req[HASH_W-1:0] = data;
    req[HASH_W +: BYTES_W] = nbytes;
    req[HASH_W+BYTES_W +: LEN_W] = len;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    hashes.note_chunk(data, nbytes, first, last, len);
    chunks_sent++;
  endtask

  // Split a key into well-formed chunks; key_length on later chunks is junk
  task automatic send_key(input int key_len, input logic [LEN_W-1:0] len_field,
                          input fill_e fill, output int chunks);
    int offs;
    int n;
    logic [HASH_W-1:0] data;
    chunks = 0;
    keys_sent++;
    if (key_len == 0) begin
      send_chunk(rand_word(), 4'd0, 1'b1, 1'b1, len_field);
      chunks = 1;
    end else begin
      offs = 0;
      while (offs < key_len) begin
        n = (key_len - offs > 8) ? 8 : key_len - offs;
        case (fill)
          FILL_ONES:  data = '1;
          FILL_ZEROS: data = '0;
          default:    data = rand_word();
        endcase
        send_chunk(data, n[BYTES_W-1:0], offs == 0, offs + 8 >= key_len,
                   (offs == 0) ? len_field : $urandom());
        chunks++;
        offs += 8;
      end
    end
  endtask

  // Drop valid and let the block settle after the last owed hash
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (hashes.owed() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [HASH_W-1:0] value);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    hashes.seed = value;
    seeds_written++;
  endtask

  // Mostly well-formed keys with random content, the rest stray chunks
  task automatic run_random(input int n_items, input bit with_hold_off);
    int sent;
    int pick;
    int key_len;
    int chunks;
    bit paused;
    sent = 0;
    paused = 1'b0;
    if (with_hold_off) begin
      hold_off_len = HOLD_OFF_CYCLES;
      hold_off_tag = ~hold_off_tag;
    end
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 88) begin
        key_len = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(24);
        send_key(key_len, ($urandom_range(4) == 0) ? $urandom() : key_len,
                 FILL_RANDOM, chunks);
        sent += chunks;
      end else begin
        send_chunk(rand_word(), BYTES_W'($urandom_range(15)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), $urandom());
        sent++;
      end
      // Pause the sender once until every owed hash is out
      if (with_hold_off && !paused && sent > n_items / 2) begin
        paused = 1'b1;
        send_key(8, 8, FILL_RANDOM, chunks);
        sent += chunks;
        wait_idle();
      end
    end
    // Close any open key before the phase ends
    send_key(3, 3, FILL_RANDOM, chunks);
  endtask

  initial begin
    int chunks;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset seed
    send_chunk(rand_word(), 4'd8, 1'b0, 1'b1, $urandom());  // no first mark from reset
    send_key(0, 0, FILL_RANDOM, chunks);                     // empty key
    send_key(8, 8, FILL_ONES, chunks);
    send_key(1, '1, FILL_ONES, chunks);
    send_key(7, 7, FILL_ONES, chunks);
    send_key(19, 19, FILL_RANDOM, chunks);
    send_key(16, 16, FILL_ZEROS, chunks);
    send_chunk(rand_word(), 4'd9, 1'b1, 1'b1, 9);           // oversized byte counts
    send_chunk(rand_word(), 4'd15, 1'b1, 1'b1, 15);
    send_chunk(rand_word(), 4'd3, 1'b1, 1'b0, 11);          // short chunk mid-key
    send_chunk(rand_word(), 4'd8, 1'b0, 1'b1, 0);
    send_chunk(rand_word(), 4'd8, 1'b1, 1'b0, 8);           // zero bytes inside a key
    send_chunk(rand_word(), 4'd0, 1'b0, 1'b0, 8);
    send_chunk(rand_word(), 4'd0, 1'b0, 1'b1, 8);
    send_chunk(rand_word(), 4'd5, 1'b0, 1'b1, $urandom());  // continue a finished key
    send_key(12, 32'h12345678, FILL_RANDOM, chunks);         // length does not match
    send_key(24, 24, FILL_RANDOM, chunks);
    wait_idle();

    // Sender light, receiver heavy
    write_seed('0);
    send_idle_pct = 18;
    recv_idle_pct = 63;
    run_random(230, 1'b0);
    wait_idle();

    // Sender heavy, receiver light
    write_seed('1);
    send_idle_pct = 63;
    recv_idle_pct = 18;
    run_random(230, 1'b0);
    wait_idle();

    // Full rate, with a long receiver hold-off
    write_seed(rand_word());
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(240, 1'b1);
    wait_idle();

    if (hashes.owed() != 0) hashes.report($sformatf("%0d hashes never delivered", hashes.owed()));
    $display("covered %0d chunks in %0d keys, %0d hashes checked, %0d seed writes",
             chunks_sent, keys_sent, hashes.hashes_checked, seeds_written);
    $display("mismatches: %0d", hashes.mismatches);
    if (hashes.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
